// ===== src/mrf_pkg.sv =====
// shared types, constants and the crc fold for the meter request framer
package mrf_pkg;

  localparam int unsigned FrameLen = 14;
  localparam int unsigned CrcSpan  = 12;
  localparam int unsigned IdxW     = 4;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  LenByte = 8'd14;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgMeterAddress = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCommandCode  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRequestId    = 2'd2;

  localparam logic [7:0] CommandReset = 8'd1;

  typedef enum logic {
    OpRequest  = 1'b0,
    OpResponse = 1'b1
  } op_e;

  typedef enum logic {
    ResTx      = 1'b0,
    ResVerdict = 1'b1
  } res_kind_e;

  typedef enum logic {
    StIdle  = 1'b0,
    StFrame = 1'b1
  } back_state_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] mask;
    logic [7:0]  rx_byte;
    logic        rx_last;
  } cmd_t;

  typedef struct packed {
    res_kind_e  result_kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       crc_ok;
  } res_t;

  typedef struct packed {
    logic [31:0] meter_address;
    logic [7:0]  command_code;
    logic [7:0]  request_id;
  } cfg_t;

  // one byte into a reflected crc-16 register, bit by bit
  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

// ===== src/meter_request_framer_crc16_top.sv =====
// top level: config registers, front end, back end and result queue
// a request's frame is sent one byte per cycle while the result queue has room
// the frame sequencer takes no new command until a request's whole frame is sent
// the command queue and the result queue let input and output stall independently
// reset: asynchronous active low; queues empty, check crc to all ones, config to defaults
module meter_request_framer_crc16_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [31:0] channel_mask_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        rx_last_i,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        tx_last_o,
  output logic        crc_ok_o,
  input  logic        cfg_we_i,
  input  logic [mrf_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  mrf_pkg::cfg_t cfg_q;
  mrf_pkg::cmd_t cmd;
  mrf_pkg::res_t res_in, res_out;
  logic [$bits(mrf_pkg::res_t)-1:0] res_raw;
  logic cmd_valid, cmd_pop, res_push, res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.meter_address <= 32'h0;
      cfg_q.command_code  <= mrf_pkg::CommandReset;
      cfg_q.request_id    <= 8'h00;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mrf_pkg::CfgMeterAddress: cfg_q.meter_address <= cfg_wdata_i;
        mrf_pkg::CfgCommandCode:  cfg_q.command_code  <= cfg_wdata_i[7:0];
        mrf_pkg::CfgRequestId:    cfg_q.request_id    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  mrf_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .channel_mask_i (channel_mask_i),
    .rx_byte_i      (rx_byte_i),
    .rx_last_i      (rx_last_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  mrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  mrf_fifo #(
    .Width ($bits(mrf_pkg::res_t)),
    .Depth (QueueDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_raw),
    .empty_o (empty)
  );

  assign res_out       = mrf_pkg::res_t'(res_raw);
  assign result_kind_o = res_out.result_kind;
  assign tx_byte_o     = res_out.tx_byte;
  assign tx_last_o     = res_out.tx_last;
  assign crc_ok_o      = res_out.crc_ok;

endmodule

// ===== src/mrf_fifo.sv =====
// small register queue used between the front, the back and the result ports
module mrf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/mrf_front.sv =====
// front end: takes input items, classifies them and queues commands for the back end
module mrf_front #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic          kind_i,
  input  logic [31:0]   channel_mask_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          rx_last_i,
  output logic          cmd_valid_o,
  output mrf_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);

  mrf_pkg::cmd_t cmd_in;
  logic [$bits(mrf_pkg::cmd_t)-1:0] cmd_raw;
  logic cmd_empty;

  always_comb begin
    cmd_in.op      = kind_i ? mrf_pkg::OpResponse : mrf_pkg::OpRequest;
    // fields that the operation does not use are dropped here
    cmd_in.mask    = kind_i ? 32'h0 : channel_mask_i;
    cmd_in.rx_byte = kind_i ? rx_byte_i : 8'h00;
    cmd_in.rx_last = kind_i && rx_last_i;
  end

  mrf_fifo #(
    .Width ($bits(mrf_pkg::cmd_t)),
    .Depth (Depth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty)
  );

  assign cmd_o       = mrf_pkg::cmd_t'(cmd_raw);
  assign cmd_valid_o = !cmd_empty;

endmodule

// ===== src/mrf_back.sv =====
// back end: frame sequencer with running crc, and the response crc checker
module mrf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mrf_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  mrf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          res_push_o,
  output mrf_pkg::res_t res_o,
  input  logic          res_full_i
);

  mrf_pkg::back_state_e state_q, state_d;

  logic [mrf_pkg::IdxW-1:0] idx_q, idx_d;
  logic [15:0] tx_crc_q, tx_crc_d;
  logic [31:0] mask_q, mask_d;

  logic [15:0] chk_crc_q, chk_crc_d;
  logic [7:0]  held0_q, held0_d;
  logic [7:0]  held1_q, held1_d;
  logic [1:0]  seen_q, seen_d;

  logic        start_frame, take_resp, emit_byte, frame_done;
  logic [7:0]  frame_byte;
  logic [15:0] chk_crc_new;
  logic [1:0]  seen_new;
  logic        ok;

  assign frame_done = (idx_q == mrf_pkg::IdxW'(mrf_pkg::FrameLen - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mrf_pkg::StIdle: begin
        if (cmd_valid_i && cmd_i.op == mrf_pkg::OpRequest && !res_full_i) begin
          state_d = mrf_pkg::StFrame;
        end
      end
      mrf_pkg::StFrame: begin
        if (!res_full_i && frame_done) begin
          state_d = mrf_pkg::StIdle;
        end
      end
      default: state_d = mrf_pkg::StIdle;
    endcase
  end

  // byte of the frame at the current position
  always_comb begin
    case (idx_q)
      4'd0:    frame_byte = cfg_i.meter_address[31:24];
      4'd1:    frame_byte = cfg_i.meter_address[23:16];
      4'd2:    frame_byte = cfg_i.meter_address[15:8];
      4'd3:    frame_byte = cfg_i.meter_address[7:0];
      4'd4:    frame_byte = cfg_i.command_code;
      4'd5:    frame_byte = mrf_pkg::LenByte;
      4'd6:    frame_byte = mask_q[7:0];
      4'd7:    frame_byte = mask_q[15:8];
      4'd8:    frame_byte = mask_q[23:16];
      4'd9:    frame_byte = mask_q[31:24];
      4'd10:   frame_byte = cfg_i.request_id;
      4'd11:   frame_byte = cfg_i.request_id;
      4'd12:   frame_byte = tx_crc_q[7:0];
      4'd13:   frame_byte = tx_crc_q[15:8];
      default: frame_byte = 8'h00;
    endcase
  end

  // response check: fold the oldest held byte once two are held
  always_comb begin
    chk_crc_new = (seen_q == 2'd2) ? mrf_pkg::crc16_fold(chk_crc_q, held0_q) : chk_crc_q;
    seen_new    = (seen_q == 2'd2) ? seen_q : seen_q + 2'd1;
    ok = (seen_new == 2'd2) && (held1_q == chk_crc_new[7:0])
         && (cmd_i.rx_byte == chk_crc_new[15:8]);
  end

  // outputs and datapath
  always_comb begin
    start_frame = 1'b0;
    take_resp   = 1'b0;
    emit_byte   = 1'b0;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o.result_kind = mrf_pkg::ResTx;
    res_o.tx_byte     = 8'h00;
    res_o.tx_last     = 1'b0;
    res_o.crc_ok      = 1'b0;

    idx_d     = idx_q;
    tx_crc_d  = tx_crc_q;
    mask_d    = mask_q;
    chk_crc_d = chk_crc_q;
    held0_d   = held0_q;
    held1_d   = held1_q;
    seen_d    = seen_q;

    case (state_q)
      mrf_pkg::StIdle: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == mrf_pkg::OpRequest) begin
            start_frame = 1'b1;
          end else begin
            take_resp = 1'b1;
          end
        end
      end
      mrf_pkg::StFrame: begin
        emit_byte = !res_full_i;
      end
      default: ;
    endcase

    if (start_frame) begin
      idx_d    = '0;
      tx_crc_d = mrf_pkg::CrcInit;
      mask_d   = cmd_i.mask;
    end

    if (emit_byte) begin
      res_push_o    = 1'b1;
      res_o.tx_byte = frame_byte;
      res_o.tx_last = frame_done;
      idx_d         = idx_q + mrf_pkg::IdxW'(1);
      if (idx_q < mrf_pkg::IdxW'(mrf_pkg::CrcSpan)) begin
        tx_crc_d = mrf_pkg::crc16_fold(tx_crc_q, frame_byte);
      end
    end

    if (take_resp) begin
      if (cmd_i.rx_last) begin
        res_push_o        = 1'b1;
        res_o.result_kind = mrf_pkg::ResVerdict;
        res_o.crc_ok      = ok;
        chk_crc_d = mrf_pkg::CrcInit;
        held0_d   = 8'h00;
        held1_d   = 8'h00;
        seen_d    = 2'd0;
      end else begin
        chk_crc_d = chk_crc_new;
        held0_d   = held1_q;
        held1_d   = cmd_i.rx_byte;
        seen_d    = seen_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mrf_pkg::StIdle;
      idx_q     <= '0;
      chk_crc_q <= mrf_pkg::CrcInit;
      held0_q   <= 8'h00;
      held1_q   <= 8'h00;
      seen_q    <= 2'd0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      chk_crc_q <= chk_crc_d;
      held0_q   <= held0_d;
      held1_q   <= held1_d;
      seen_q    <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_crc_q <= tx_crc_d;
    mask_q   <= mask_d;
  end

endmodule
